### hdl/wmtb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wmtb_pkg;

  // Bank geometry.
  localparam int TIMER_SLOTS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int MAX_RESULTS = 16;

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int FCNT_W = $clog2(MAX_RESULTS + 1);

  // Fixed field widths of the command and result ports.
  localparam int OPCODE_W   = 3;
  localparam int INDEX_W    = 4;
  localparam int VALUE_W    = 24;
  localparam int WEEK_W     = 7;
  localparam int WEEKDAY_W  = 3;
  localparam int KIND_W     = 2;
  localparam int STATUS_W   = 2;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_SETUP   = 3'd2,
    OP_RUN     = 3'd3,
    OP_SETIV   = 3'd4,
    OP_RELEASE = 3'd5,
    OP_QUERY   = 3'd6
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRE   = 2'd0,
    KIND_IDLE   = 2'd1,
    KIND_ANSWER = 2'd2
  } result_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_ALLOC = 2'd2
  } status_e;

  // One entry of the slot memory.
  typedef struct packed {
    logic [WEEK_W-1:0]     week_mask;
    logic [COUNT_BITS-1:0] interval;
    logic [COUNT_BITS-1:0] reload;
    logic [COUNT_BITS-1:0] elapsed;
  } slot_entry_t;

  // Access request from the controller to the slot memory.
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;
  } ram_req_t;

endpackage

`default_nettype wire

### hdl/wmtb_store.sv
`timescale 1ns / 1ps
`default_nettype none

module wmtb_store (
  input  wire                   clk_i,
  input  wire wmtb_pkg::ram_req_t req_i,
  output wmtb_pkg::slot_entry_t rd_data_o
);

  wmtb_pkg::slot_entry_t mem_q [wmtb_pkg::TIMER_SLOTS];
  wmtb_pkg::slot_entry_t rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Registered read port; the read data is held until the next enabled read.
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### hdl/wmtb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module wmtb_ctrl (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [wmtb_pkg::OPCODE_W-1:0]         opcode_i,
  input  wire  [wmtb_pkg::INDEX_W-1:0]          slot_index_i,
  input  wire  [wmtb_pkg::VALUE_W-1:0]          interval_value_i,
  input  wire  [wmtb_pkg::VALUE_W-1:0]          reload_interval_i,
  input  wire                                   periodic_mode_i,
  input  wire  [wmtb_pkg::WEEK_W-1:0]           week_mask_i,
  input  wire                                   start_flag_i,
  input  wire  [wmtb_pkg::WEEKDAY_W-1:0]        weekday_i,
  output logic                                  result_valid_o,
  output logic [wmtb_pkg::KIND_W-1:0]           result_kind_o,
  output logic [wmtb_pkg::INDEX_W-1:0]          result_slot_o,
  output logic [wmtb_pkg::STATUS_W-1:0]         status_code_o,
  output logic                                  run_state_o,
  output logic                                  last_result_o,
  output wmtb_pkg::ram_req_t                    ram_req_o,
  input  wire wmtb_pkg::slot_entry_t            ram_rdata_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMD   = 4'b0010,
    S_TICK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  localparam logic [wmtb_pkg::WEEKDAY_W-1:0] SUNDAY_BIT = 3'd6;

  // Weekday 0 (and the unused code 7) select the Sunday bit; other days shift down by one.
  function automatic logic [wmtb_pkg::WEEKDAY_W-1:0] day_bit(
    input logic [wmtb_pkg::WEEKDAY_W-1:0] wd
  );
    if (wd == 3'd0 || wd == 3'd7) begin
      return SUNDAY_BIT;
    end
    return wd - 3'd1;
  endfunction

  state_e state_q, state_d;

  // Per-slot flags in flip-flops, cleared by reset.
  logic [wmtb_pkg::TIMER_SLOTS-1:0] in_use_q, in_use_d;
  logic [wmtb_pkg::TIMER_SLOTS-1:0] set_up_q, set_up_d;
  logic [wmtb_pkg::TIMER_SLOTS-1:0] running_q, running_d;
  logic [wmtb_pkg::TIMER_SLOTS-1:0] periodic_q, periodic_d;

  // Captured request fields.
  wmtb_pkg::opcode_e                   op_q, op_d;
  logic [wmtb_pkg::SLOT_W-1:0]         slot_q, slot_d;
  logic [wmtb_pkg::COUNT_BITS-1:0]     ival_q, ival_d;
  logic [wmtb_pkg::COUNT_BITS-1:0]     rval_q, rval_d;
  logic                                per_q, per_d;
  logic [wmtb_pkg::WEEK_W-1:0]         mask_q, mask_d;
  logic                                run_flag_q, run_flag_d;
  logic [wmtb_pkg::WEEKDAY_W-1:0]      bit_q, bit_d;

  // Tick sweep state.
  logic [wmtb_pkg::SLOT_W-1:0]         proc_q, proc_d;
  logic                                pend_valid_q, pend_valid_d;
  logic [wmtb_pkg::SLOT_W-1:0]         pend_slot_q, pend_slot_d;
  logic [wmtb_pkg::FCNT_W-1:0]         fcnt_q, fcnt_d;

  // Result register.
  logic                                out_valid_q, out_valid_d;
  wmtb_pkg::result_kind_e              out_kind_q, out_kind_d;
  logic [wmtb_pkg::INDEX_W-1:0]        out_slot_q, out_slot_d;
  wmtb_pkg::status_e                   out_status_q, out_status_d;
  logic                                out_run_q, out_run_d;
  logic                                out_last_q, out_last_d;

  // Decode helpers.
  wmtb_pkg::opcode_e                   op_in;
  logic [wmtb_pkg::SLOT_W-1:0]         idx;
  logic                                idx_ok;
  logic                                free_found;
  logic [wmtb_pkg::SLOT_W-1:0]         free_idx;

  // Tick datapath.
  logic                                act;
  logic [wmtb_pkg::COUNT_BITS-1:0]     el_inc;
  logic                                hit;
  logic                                day_ok;
  logic                                fire;
  wmtb_pkg::slot_entry_t               tick_entry;
  wmtb_pkg::slot_entry_t               cmd_entry;
  wmtb_pkg::ram_req_t                  req;

  assign op_in = wmtb_pkg::opcode_e'(opcode_i);
  assign idx   = wmtb_pkg::SLOT_W'(slot_index_i);

  // A slot index names an allocated slot only when it is inside the bank.
  always_comb begin
    idx_ok = 1'b0;
    if (32'(slot_index_i) < wmtb_pkg::TIMER_SLOTS) begin
      idx_ok = in_use_q[idx];
    end
  end

  // Lowest free slot for allocation.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = wmtb_pkg::TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = wmtb_pkg::SLOT_W'(i);
      end
    end
  end

  // Update of the slot that the sweep reads back this cycle.
  always_comb begin
    act    = in_use_q[proc_q] & set_up_q[proc_q] & running_q[proc_q];
    el_inc = (ram_rdata_i.elapsed == wmtb_pkg::COUNT_MAX) ? ram_rdata_i.elapsed
                                                          : ram_rdata_i.elapsed + 1'b1;
    hit    = (el_inc >= ram_rdata_i.interval);
    day_ok = (ram_rdata_i.week_mask == '0) || ram_rdata_i.week_mask[bit_q];
    fire   = act & hit & day_ok;
    tick_entry         = ram_rdata_i;
    tick_entry.elapsed = el_inc;
    if (hit && periodic_q[proc_q]) begin
      tick_entry.elapsed  = '0;
      tick_entry.interval = ram_rdata_i.reload;
    end
  end

  // Entry written back by the commands that read and then write the slot memory.
  always_comb begin
    cmd_entry = ram_rdata_i;
    unique case (op_q)
      wmtb_pkg::OP_ALLOC: begin
        cmd_entry.interval = '0;
        cmd_entry.elapsed  = '0;
      end
      wmtb_pkg::OP_SETUP: begin
        cmd_entry.week_mask = mask_q;
        cmd_entry.interval  = ival_q;
        cmd_entry.reload    = rval_q;
        cmd_entry.elapsed   = '0;
      end
      wmtb_pkg::OP_RUN: begin
        if (run_flag_q && periodic_q[slot_q]) begin
          cmd_entry.elapsed  = '0;
          cmd_entry.interval = ram_rdata_i.reload;
        end
      end
      wmtb_pkg::OP_SETIV: begin
        cmd_entry.elapsed  = '0;
        cmd_entry.interval = ival_q;
      end
      default: begin
        cmd_entry = ram_rdata_i;
      end
    endcase
  end

  // Main sequencer.
  always_comb begin
    state_d      = state_q;
    in_use_d     = in_use_q;
    set_up_d     = set_up_q;
    running_d    = running_q;
    periodic_d   = periodic_q;
    op_d         = op_q;
    slot_d       = slot_q;
    ival_d       = ival_q;
    rval_d       = rval_q;
    per_d        = per_q;
    mask_d       = mask_q;
    run_flag_d   = run_flag_q;
    bit_d        = bit_q;
    proc_d       = proc_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    fcnt_d       = fcnt_q;
    out_valid_d  = 1'b0;
    out_kind_d   = wmtb_pkg::KIND_ANSWER;
    out_slot_d   = '0;
    out_status_d = wmtb_pkg::STAT_OK;
    out_run_d    = 1'b0;
    out_last_d   = 1'b1;
    req          = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          op_d       = op_in;
          slot_d     = idx;
          ival_d     = wmtb_pkg::COUNT_BITS'(interval_value_i);
          rval_d     = wmtb_pkg::COUNT_BITS'(reload_interval_i);
          per_d      = periodic_mode_i;
          mask_d     = week_mask_i;
          run_flag_d = start_flag_i;
          bit_d      = day_bit(weekday_i);
          unique case (op_in)
            wmtb_pkg::OP_TICK: begin
              req.rd_en    = 1'b1;
              req.rd_addr  = '0;
              proc_d       = '0;
              pend_valid_d = 1'b0;
              fcnt_d       = '0;
              state_d      = S_TICK;
            end
            wmtb_pkg::OP_ALLOC: begin
              if (free_found) begin
                slot_d      = free_idx;
                req.rd_en   = 1'b1;
                req.rd_addr = free_idx;
                state_d     = S_CMD;
              end else begin
                out_valid_d  = 1'b1;
                out_status_d = wmtb_pkg::STAT_FULL;
              end
            end
            wmtb_pkg::OP_SETUP, wmtb_pkg::OP_RUN, wmtb_pkg::OP_SETIV: begin
              if (idx_ok) begin
                req.rd_en   = 1'b1;
                req.rd_addr = idx;
                state_d     = S_CMD;
              end else begin
                out_valid_d  = 1'b1;
                out_status_d = wmtb_pkg::STAT_NOT_ALLOC;
              end
            end
            wmtb_pkg::OP_RELEASE: begin
              out_valid_d = 1'b1;
              if (idx_ok) begin
                in_use_d[idx]   = 1'b0;
                set_up_d[idx]   = 1'b0;
                running_d[idx]  = 1'b0;
                periodic_d[idx] = 1'b0;
              end else begin
                out_status_d = wmtb_pkg::STAT_NOT_ALLOC;
              end
            end
            wmtb_pkg::OP_QUERY: begin
              out_valid_d = 1'b1;
              if (idx_ok) begin
                out_run_d = running_q[idx];
              end else begin
                out_status_d = wmtb_pkg::STAT_NOT_ALLOC;
              end
            end
            default: begin
              // The unused opcode is dropped without a result.
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Command write-back: memory data is back, write it and answer.
      S_CMD: begin
        req.wr_en   = 1'b1;
        req.wr_addr = slot_q;
        req.wr_data = cmd_entry;
        out_valid_d = 1'b1;
        unique case (op_q)
          wmtb_pkg::OP_ALLOC: begin
            in_use_d[slot_q]   = 1'b1;
            set_up_d[slot_q]   = 1'b0;
            running_d[slot_q]  = 1'b0;
            periodic_d[slot_q] = 1'b0;
            out_slot_d         = wmtb_pkg::INDEX_W'(slot_q);
          end
          wmtb_pkg::OP_SETUP: begin
            set_up_d[slot_q]   = 1'b1;
            running_d[slot_q]  = run_flag_q;
            periodic_d[slot_q] = per_q;
          end
          wmtb_pkg::OP_RUN: begin
            running_d[slot_q] = run_flag_q;
          end
          default: begin
            running_d[slot_q] = running_q[slot_q];
          end
        endcase
        state_d = S_IDLE;
      end

      // One slot per cycle: read the next slot while writing back this one.
      S_TICK: begin
        if (32'(proc_q) < wmtb_pkg::TIMER_SLOTS - 1) begin
          req.rd_en   = 1'b1;
          req.rd_addr = proc_q + 1'b1;
          proc_d      = proc_q + 1'b1;
        end
        if (act) begin
          req.wr_en   = 1'b1;
          req.wr_addr = proc_q;
          req.wr_data = tick_entry;
          if (hit && !periodic_q[proc_q]) begin
            running_d[proc_q] = 1'b0;
          end
        end
        // A fire is held back until the next fire or the flush, so that the final one can carry the last flag.
        if (fire && (fcnt_q < wmtb_pkg::FCNT_W'(wmtb_pkg::MAX_RESULTS))) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_kind_d  = wmtb_pkg::KIND_FIRE;
            out_slot_d  = wmtb_pkg::INDEX_W'(pend_slot_q);
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_slot_d  = proc_q;
          fcnt_d       = fcnt_q + 1'b1;
        end
        if (proc_q == wmtb_pkg::SLOT_W'(wmtb_pkg::TIMER_SLOTS - 1)) begin
          state_d = S_FLUSH;
        end
      end

      // Final tick result: the held fire, or the nothing-fired marker.
      S_FLUSH: begin
        out_valid_d = 1'b1;
        if (pend_valid_q) begin
          out_kind_d = wmtb_pkg::KIND_FIRE;
          out_slot_d = wmtb_pkg::INDEX_W'(pend_slot_q);
        end else begin
          out_kind_d = wmtb_pkg::KIND_IDLE;
        end
        pend_valid_d = 1'b0;
        state_d      = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      in_use_q     <= '0;
      set_up_q     <= '0;
      running_q    <= '0;
      periodic_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      in_use_q     <= in_use_d;
      set_up_q     <= set_up_d;
      running_q    <= running_d;
      periodic_q   <= periodic_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    slot_q       <= slot_d;
    ival_q       <= ival_d;
    rval_q       <= rval_d;
    per_q        <= per_d;
    mask_q       <= mask_d;
    run_flag_q   <= run_flag_d;
    bit_q        <= bit_d;
    proc_q       <= proc_d;
    pend_slot_q  <= pend_slot_d;
    fcnt_q       <= fcnt_d;
    out_kind_q   <= out_kind_d;
    out_slot_q   <= out_slot_d;
    out_status_q <= out_status_d;
    out_run_q    <= out_run_d;
    out_last_q   <= out_last_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign ram_req_o      = req;
  assign result_valid_o = out_valid_q;
  assign result_kind_o  = out_kind_q;
  assign result_slot_o  = out_slot_q;
  assign status_code_o  = out_status_q;
  assign run_state_o    = out_run_q;
  assign last_result_o  = out_last_q;

endmodule

`default_nettype wire

### hdl/weekday_masked_timer_bank.sv
// Bank of software-style timer slots driven by one request at a time. A request is taken when
// start is high and busy is low. Release, query, rejected requests and the unused opcode finish
// without leaving idle; allocate, set up, run status and set interval read the slot memory, then
// write it back. A tick sweeps the slots one per cycle through the single read port of the slot
// memory, then gives the final result in a flush state.
// Results are registered before they appear on the result ports, each for exactly one
// cycle with result_valid_o high; the receiver cannot stall them. Fire results of a tick come in
// slot order, one per cycle at most, and the last result a request gives has last_result_o set.
`timescale 1ns / 1ps
`default_nettype none

module weekday_masked_timer_bank (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire  [wmtb_pkg::OPCODE_W-1:0]  opcode_i,
  input  wire  [wmtb_pkg::INDEX_W-1:0]   slot_index_i,
  input  wire  [wmtb_pkg::VALUE_W-1:0]   interval_value_i,
  input  wire  [wmtb_pkg::VALUE_W-1:0]   reload_interval_i,
  input  wire                            periodic_mode_i,
  input  wire  [wmtb_pkg::WEEK_W-1:0]    week_mask_i,
  input  wire                            start_flag_i,
  input  wire  [wmtb_pkg::WEEKDAY_W-1:0] weekday_i,
  output logic                           result_valid_o,
  output logic [wmtb_pkg::KIND_W-1:0]    result_kind_o,
  output logic [wmtb_pkg::INDEX_W-1:0]   result_slot_o,
  output logic [wmtb_pkg::STATUS_W-1:0]  status_code_o,
  output logic                           run_state_o,
  output logic                           last_result_o
);

  wmtb_pkg::ram_req_t    ram_req;
  wmtb_pkg::slot_entry_t ram_rdata;

  // Sequencer, slot flags and result register.
  wmtb_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .slot_index_i      (slot_index_i),
    .interval_value_i  (interval_value_i),
    .reload_interval_i (reload_interval_i),
    .periodic_mode_i   (periodic_mode_i),
    .week_mask_i       (week_mask_i),
    .start_flag_i      (start_flag_i),
    .weekday_i         (weekday_i),
    .result_valid_o    (result_valid_o),
    .result_kind_o     (result_kind_o),
    .result_slot_o     (result_slot_o),
    .status_code_o     (status_code_o),
    .run_state_o       (run_state_o),
    .last_result_o     (last_result_o),
    .ram_req_o         (ram_req),
    .ram_rdata_i       (ram_rdata)
  );

  // Slot memory: mask, interval, reload and elapsed count of every slot.
  wmtb_store u_store (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rdata)
  );

endmodule

`default_nettype wire

### hdl/wmtb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module wmtb_checker (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            start,
  input wire                            busy,
  input wire [wmtb_pkg::OPCODE_W-1:0]   opcode_i,
  input wire                            result_valid_o,
  input wire [wmtb_pkg::KIND_W-1:0]     result_kind_o,
  input wire [wmtb_pkg::INDEX_W-1:0]    result_slot_o,
  input wire [wmtb_pkg::STATUS_W-1:0]   status_code_o,
  input wire                            run_state_o,
  input wire                            last_result_o
);

  // A final result only shows once the block is free again; earlier ones show while busy.
  a_last_vs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (busy == !last_result_o))
    else $error("last flag does not match busy state");

  // A tick request keeps the block busy for its sweep.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && opcode_i == wmtb_pkg::OP_TICK |=> busy)
    else $error("tick request did not start a sweep");

  // A query is answered in the next cycle with a single final answer.
  a_query_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && opcode_i == wmtb_pkg::OP_QUERY |=>
      result_valid_o && result_kind_o == wmtb_pkg::KIND_ANSWER && last_result_o && !busy)
    else $error("query not answered in the next cycle");

  // Only command answers report a running slot.
  a_run_only_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && run_state_o |-> result_kind_o == wmtb_pkg::KIND_ANSWER)
    else $error("run state set on a tick result");

  // The nothing-fired marker carries no slot and no status.
  a_idle_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_kind_o == wmtb_pkg::KIND_IDLE |->
      result_slot_o == '0 && status_code_o == wmtb_pkg::STAT_OK)
    else $error("nothing-fired result carries a slot or status");

endmodule

bind weekday_masked_timer_bank wmtb_checker u_wmtb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .opcode_i       (opcode_i),
  .result_valid_o (result_valid_o),
  .result_kind_o  (result_kind_o),
  .result_slot_o  (result_slot_o),
  .status_code_o  (status_code_o),
  .run_state_o    (run_state_o),
  .last_result_o  (last_result_o)
);

`default_nettype wire

### test/timer_bank_monitor.sv
`timescale 1ns / 1ps

// Watches the request and result channels of the timer bank, keeps its own copy
// of the slot state, works out the results each accepted request must give, and
// compares every result strobe against the oldest one still owed.
module timer_bank_monitor
  import wmtb_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start,
  input  wire                   busy,
  input  wire  [OPCODE_W-1:0]   opcode_i,
  input  wire  [INDEX_W-1:0]    slot_index_i,
  input  wire  [VALUE_W-1:0]    interval_value_i,
  input  wire  [VALUE_W-1:0]    reload_interval_i,
  input  wire                   periodic_mode_i,
  input  wire  [WEEK_W-1:0]     week_mask_i,
  input  wire                   start_flag_i,
  input  wire  [WEEKDAY_W-1:0]  weekday_i,
  input  wire                   result_valid_o,
  input  wire  [KIND_W-1:0]     result_kind_o,
  input  wire  [INDEX_W-1:0]    result_slot_o,
  input  wire  [STATUS_W-1:0]   status_code_o,
  input  wire                   run_state_o,
  input  wire                   last_result_o,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    result_kind_e         kind;
    logic [INDEX_W-1:0]   slot;
    status_e              status;
    logic                 run;
    logic                 last;
  } timer_result_t;

  // Shadow copy of the slot bank.
  bit                    in_use   [TIMER_SLOTS];
  bit                    set_up   [TIMER_SLOTS];
  bit                    running  [TIMER_SLOTS];
  bit                    periodic [TIMER_SLOTS];
  logic [WEEK_W-1:0]     day_mask [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] interval [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] reload   [TIMER_SLOTS];
  logic [COUNT_BITS-1:0] elapsed  [TIMER_SLOTS];

  timer_result_t owed_results[$];
  int            mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Apply one accepted request to the shadow bank and queue the results it owes.
  function automatic void apply_request(
    input logic [OPCODE_W-1:0]  op,
    input logic [INDEX_W-1:0]   idx,
    input logic [VALUE_W-1:0]   ival,
    input logic [VALUE_W-1:0]   rval,
    input logic                 per,
    input logic [WEEK_W-1:0]    wmask,
    input logic                 run_flag,
    input logic [WEEKDAY_W-1:0] wday
  );
    timer_result_t batch[$];
    timer_result_t r;
    int            day_bit;
    int            free_slot;
    int            s;

    r.kind   = KIND_ANSWER;
    r.slot   = '0;
    r.status = STAT_OK;
    r.run    = 1'b0;
    r.last   = 1'b0;

    // The unused opcode is taken but answers nothing.
    if (op > OP_QUERY) return;

    case (op)
      OP_TICK: begin
        // Sunday and the out-of-range weekday both map to the top mask bit.
        day_bit = (wday == 0 || wday == 7) ? 6 : int'(wday) - 1;
        for (s = 0; s < TIMER_SLOTS; s++) begin
          if (in_use[s] && set_up[s] && running[s]) begin
            if (elapsed[s] != COUNT_MAX) elapsed[s] = elapsed[s] + 1'b1;
            if (elapsed[s] >= interval[s]) begin
              if ((day_mask[s] == '0 || day_mask[s][day_bit]) &&
                  batch.size() < MAX_RESULTS) begin
                r.kind = KIND_FIRE;
                r.slot = INDEX_W'(s);
                batch.push_back(r);
              end
              // A slot at its interval reloads or stops whether it fired or not.
              if (periodic[s]) begin
                elapsed[s]  = '0;
                interval[s] = reload[s];
              end else begin
                running[s] = 1'b0;
              end
            end
          end
        end
        if (batch.size() == 0) begin
          r.kind = KIND_IDLE;
          batch.push_back(r);
        end
      end
      OP_ALLOC: begin
        free_slot = -1;
        for (s = TIMER_SLOTS - 1; s >= 0; s--) begin
          if (!in_use[s]) free_slot = s;
        end
        if (free_slot < 0) begin
          r.status = STAT_FULL;
        end else begin
          in_use[free_slot]   = 1'b1;
          set_up[free_slot]   = 1'b0;
          running[free_slot]  = 1'b0;
          periodic[free_slot] = 1'b0;
          interval[free_slot] = '0;
          elapsed[free_slot]  = '0;
          r.slot = INDEX_W'(free_slot);
        end
        batch.push_back(r);
      end
      default: begin
        if (int'(idx) >= TIMER_SLOTS || !in_use[idx]) begin
          r.status = STAT_NOT_ALLOC;
        end else begin
          case (op)
            OP_SETUP: begin
              day_mask[idx] = wmask;
              interval[idx] = ival[COUNT_BITS-1:0];
              reload[idx]   = rval[COUNT_BITS-1:0];
              periodic[idx] = per;
              elapsed[idx]  = '0;
              running[idx]  = run_flag;
              set_up[idx]   = 1'b1;
            end
            OP_RUN: begin
              running[idx] = run_flag;
              // Starting a periodic slot restarts it on its reload interval.
              if (run_flag && periodic[idx]) begin
                elapsed[idx]  = '0;
                interval[idx] = reload[idx];
              end
            end
            OP_SETIV: begin
              elapsed[idx]  = '0;
              interval[idx] = ival[COUNT_BITS-1:0];
            end
            OP_RELEASE: begin
              in_use[idx]   = 1'b0;
              set_up[idx]   = 1'b0;
              running[idx]  = 1'b0;
              periodic[idx] = 1'b0;
            end
            default: r.run = running[idx];
          endcase
        end
        batch.push_back(r);
      end
    endcase

    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) owed_results.push_back(batch[k]);
  endfunction

  // Compare strobed results first, then predict for a request taken at this edge.
  always @(posedge clk_i or negedge rst_ni) begin
    timer_result_t want;
    if (!rst_ni) begin
      for (int s = 0; s < TIMER_SLOTS; s++) begin
        in_use[s]   = 1'b0;
        set_up[s]   = 1'b0;
        running[s]  = 1'b0;
        periodic[s] = 1'b0;
        day_mask[s] = '0;
        interval[s] = '0;
        reload[s]   = '0;
        elapsed[s]  = '0;
      end
      owed_results.delete();
      pending_o = 0;
    end else begin
      if (result_valid_o) begin
        if (owed_results.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual kind %0d slot %0d",
                   $time, result_kind_o, result_slot_o);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          check_field("result_kind", want.kind, result_kind_o);
          check_field("result_slot", want.slot, result_slot_o);
          check_field("status_code", want.status, status_code_o);
          check_field("run_state", want.run, run_state_o);
          check_field("last_result", want.last, last_result_o);
        end
      end
      if (start && !busy) begin
        apply_request(opcode_i, slot_index_i, interval_value_i, reload_interval_i,
                      periodic_mode_i, week_mask_i, start_flag_i, weekday_i);
      end
      pending_o = owed_results.size();
    end
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

// Drives requests into the timer bank and gives the verdict; the monitor does
// the prediction and the comparison.
module tb_top;
  import wmtb_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_REQUESTS = 330;
  localparam int DRAIN_CYCLES    = 2 * TIMER_SLOTS + 8;
  localparam int WATCHDOG_LIMIT  = 2000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [OPCODE_W-1:0]   opcode_i;
  logic [INDEX_W-1:0]    slot_index_i;
  logic [VALUE_W-1:0]    interval_value_i;
  logic [VALUE_W-1:0]    reload_interval_i;
  logic                  periodic_mode_i;
  logic [WEEK_W-1:0]     week_mask_i;
  logic                  start_flag_i;
  logic [WEEKDAY_W-1:0]  weekday_i;
  logic                  result_valid_o;
  logic [KIND_W-1:0]     result_kind_o;
  logic [INDEX_W-1:0]    result_slot_o;
  logic [STATUS_W-1:0]   status_code_o;
  logic                  run_state_o;
  logic                  last_result_o;
  int                    fail_count;
  int                    pending;
  bit                    gaps_on;

  weekday_masked_timer_bank u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .slot_index_i      (slot_index_i),
    .interval_value_i  (interval_value_i),
    .reload_interval_i (reload_interval_i),
    .periodic_mode_i   (periodic_mode_i),
    .week_mask_i       (week_mask_i),
    .start_flag_i      (start_flag_i),
    .weekday_i         (weekday_i),
    .result_valid_o    (result_valid_o),
    .result_kind_o     (result_kind_o),
    .result_slot_o     (result_slot_o),
    .status_code_o     (status_code_o),
    .run_state_o       (run_state_o),
    .last_result_o     (last_result_o)
  );

  timer_bank_monitor u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .slot_index_i      (slot_index_i),
    .interval_value_i  (interval_value_i),
    .reload_interval_i (reload_interval_i),
    .periodic_mode_i   (periodic_mode_i),
    .week_mask_i       (week_mask_i),
    .start_flag_i      (start_flag_i),
    .weekday_i         (weekday_i),
    .result_valid_o    (result_valid_o),
    .result_kind_o     (result_kind_o),
    .result_slot_o     (result_slot_o),
    .status_code_o     (status_code_o),
    .run_state_o       (run_state_o),
    .last_result_o     (last_result_o),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Ends the run when neither a request nor a result moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || result_valid_o) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Mostly short intervals so that slots fire often, with some extremes.
  function automatic logic [VALUE_W-1:0] pick_interval();
    int roll;
    roll = $urandom_range(9);
    if (roll < 7) return VALUE_W'($urandom_range(6));
    if (roll == 7) return VALUE_W'($urandom());
    if (roll == 8) return '1;
    return VALUE_W'($urandom_range(40));
  endfunction

  // Issue one request, entered and left at a falling edge; holds until taken.
  task automatic issue(
    input logic [OPCODE_W-1:0]  op,
    input logic [INDEX_W-1:0]   idx,
    input logic [VALUE_W-1:0]   ival,
    input logic [VALUE_W-1:0]   rval,
    input logic                 per,
    input logic [WEEK_W-1:0]    wmask,
    input logic                 run_flag,
    input logic [WEEKDAY_W-1:0] wday
  );
    if (gaps_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start             <= 1'b1;
    opcode_i          <= op;
    slot_index_i      <= idx;
    interval_value_i  <= ival;
    reload_interval_i <= rval;
    periodic_mode_i   <= per;
    week_mask_i       <= wmask;
    start_flag_i      <= run_flag;
    weekday_i         <= wday;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  initial begin
    logic [OPCODE_W-1:0] op;
    int                  roll;

    rst_ni            = 1'b0;
    start             = 1'b0;
    opcode_i          = '0;
    slot_index_i      = '0;
    interval_value_i  = '0;
    reload_interval_i = '0;
    periodic_mode_i   = 1'b0;
    week_mask_i       = '0;
    start_flag_i      = 1'b0;
    weekday_i         = '0;
    gaps_on           = 1'b1;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty bank, unused opcode, filling the bank past full.
    issue(OP_QUERY, 4'd15, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(OP_UNUSED, '0, '1, '1, 1'b1, '1, 1'b1, '1);
    repeat (TIMER_SLOTS + 1) issue(OP_ALLOC, '0, '0, '0, 1'b0, '0, 1'b0, '0);

    // Directed: zero and full-scale intervals, Sunday-only mask, weekday seven.
    issue(OP_SETUP, 4'd0, '0, 24'd1, 1'b1, '0, 1'b1, '0);
    issue(OP_SETUP, 4'd1, '1, '1, 1'b0, 7'h40, 1'b1, '0);
    issue(OP_TICK, '0, '0, '0, 1'b0, '0, 1'b0, 3'd7);
    issue(OP_SETIV, 4'd1, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(OP_RUN, 4'd0, '0, '0, 1'b0, '0, 1'b1, '0);
    issue(OP_TICK, '0, '0, '0, 1'b0, '0, 1'b0, 3'd1);
    issue(OP_QUERY, 4'd0, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(OP_RELEASE, 4'd1, '0, '0, 1'b0, '0, 1'b0, '0);
    issue(OP_QUERY, 4'd1, '0, '0, 1'b0, '0, 1'b0, '0);

    // Random traffic, weighted toward ticks and set-ups of low slots.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      gaps_on = !(n >= 60 && n < 140);
      // Hold off until every owed result is back.
      if (n == 200) begin
        start <= 1'b0;
        do @(negedge clk_i); while (pending != 0);
      end
      roll = $urandom_range(99);
      if (roll < 36)      op = OP_TICK;
      else if (roll < 46) op = OP_ALLOC;
      else if (roll < 62) op = OP_SETUP;
      else if (roll < 74) op = OP_RUN;
      else if (roll < 82) op = OP_SETIV;
      else if (roll < 90) op = OP_RELEASE;
      else if (roll < 98) op = OP_QUERY;
      else                op = OP_UNUSED;
      issue(op,
            ($urandom_range(3) != 0) ? INDEX_W'($urandom_range(7))
                                     : INDEX_W'($urandom_range(15)),
            pick_interval(), pick_interval(), 1'($urandom_range(1)),
            ($urandom_range(3) == 0) ? '0 : WEEK_W'($urandom_range(127)),
            1'($urandom_range(3) != 0), WEEKDAY_W'($urandom_range(7)));
    end
    start <= 1'b0;

    // Let every owed result arrive, then watch a little longer for strays.
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### weekday_masked_timer_bank.f
hdl/wmtb_pkg.sv
hdl/wmtb_store.sv
hdl/wmtb_ctrl.sv
hdl/weekday_masked_timer_bank.sv
hdl/wmtb_checker.sv
test/timer_bank_monitor.sv
test/tb_top.sv
